[hw/rtl/decimal_text_to_q16_16_assert.svh]
// Assertion macros for the decimal text to Q16.16 converter.
`ifndef DECIMAL_TEXT_TO_Q16_16_ASSERT_SVH
`define DECIMAL_TEXT_TO_Q16_16_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define DT_ASSERT_NOW(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define DT_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define DT_ASSERT_NOW(lbl, clk, rstn, a, b)
`define DT_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif
`endif

[hw/rtl/dtq_pkg.sv]
// Package for the decimal text to Q16.16 converter: types, constants, power-of-ten table.
package dtq_pkg;

    localparam int MAX_FRAC_DIGITS_DEF = 7;
    localparam int FRAC_BITS = 16;
    localparam int QUO_BITS  = 17;

    localparam logic [7:0]  CH_MINUS  = 8'h2D;
    localparam logic [7:0]  CH_POINT  = 8'h2E;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [14:0] WHOLE_MAX = 15'd32767;

    typedef enum logic [1:0] {
        PH_START,
        PH_INT,
        PH_FRAC,
        PH_FAIL
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    // 10^k as a constant table, k clamped to 9
    function automatic longint unsigned pow10(input int k);
        longint unsigned p;
        unique case (k)
            0:       p = 64'd1;
            1:       p = 64'd10;
            2:       p = 64'd100;
            3:       p = 64'd1000;
            4:       p = 64'd10000;
            5:       p = 64'd100000;
            6:       p = 64'd1000000;
            7:       p = 64'd10000000;
            8:       p = 64'd100000000;
            default: p = 64'd1000000000;
        endcase
        return p;
    endfunction

endpackage

[hw/rtl/decimal_text_to_q16_16.sv]
// Decimal text to signed Q16.16 converter, top level.
// Characters stream in one per transfer; a transfer with i_end_of_text set closes the
// string and yields one result (o_ok, o_value). Text characters are taken one per clock
// while no divide is running. The end-of-text transfer starts a restoring divide of the
// scaled fraction by its power of ten on one shared compare-subtract unit, one quotient
// bit per cycle, then a finish state; no transfer is taken until the finish state is
// over. The result sits in an output register; characters of the next string keep
// flowing while it waits, only a new end-of-text transfer holds until the result is
// taken. Failed strings still run the divide but report ok = 0, value = 0.
`include "decimal_text_to_q16_16_assert.svh"

module decimal_text_to_q16_16
    import dtq_pkg::*;
#(
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // character channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_ch,
    input  logic               i_end_of_text,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_ok,
    output logic signed [31:0] o_value
);

    // kept fraction digits fit below 10^MAX_FRAC_DIGITS
    localparam int FRAC_W = $clog2(pow10(MAX_FRAC_DIGITS));
    localparam int FXW    = FRAC_W + 4;
    localparam int KW     = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int DW     = FRAC_W + QUO_BITS;
    localparam int CW     = $clog2(QUO_BITS);

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic                r_neg, n_neg;
    logic [14:0]         r_whole, n_whole;
    logic [FRAC_W-1:0]   r_frac, n_frac;
    logic [KW-1:0]       r_kept, n_kept;
    logic                r_saw, n_saw;
    logic                r_fail, n_fail;

    // divide unit
    logic [DW-1:0]       r_rem, n_rem;
    logic [DW-1:0]       r_div, n_div;
    logic [QUO_BITS-1:0] r_quo, n_quo;
    logic [CW-1:0]       r_cnt, n_cnt;

    // output register
    logic                r_out_valid, n_out_valid;
    logic                r_out_ok, n_out_ok;
    logic signed [31:0]  r_out_value, n_out_value;

    logic                in_acc;
    logic                is_digit;
    logic [3:0]          dgt;
    logic [18:0]         whole_next;
    logic [FXW-1:0]      frac_next;
    logic [FRAC_W-1:0]   scale;
    logic                ge;
    logic [31:0]         raw;
    logic                res_ok;

    // an end-of-text transfer needs a free output register
    assign o_stall = (r_state != S_IDLE) | (r_out_valid & i_end_of_text);
    assign in_acc  = i_valid & ~o_stall;

    assign is_digit   = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign dgt        = 4'(i_ch - CH_ZERO);
    assign whole_next = 19'(r_whole) * 19'd10 + 19'(dgt);
    assign frac_next  = FXW'(r_frac) * FXW'(10) + FXW'(dgt);
    assign scale      = FRAC_W'(pow10(int'(r_kept)));
    assign ge         = (r_rem >= r_div);
    // quotient is at most 2^16, so the sum tops out at 2^31
    assign raw        = {1'b0, r_whole, 16'b0} + 32'(r_quo);
    assign res_ok     = ~r_fail & ~raw[31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_START;
            r_neg       <= 1'b0;
            r_whole     <= '0;
            r_frac      <= '0;
            r_kept      <= '0;
            r_saw       <= 1'b0;
            r_fail      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_whole     <= n_whole;
            r_frac      <= n_frac;
            r_kept      <= n_kept;
            r_saw       <= n_saw;
            r_fail      <= n_fail;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_quo       <= n_quo;
        r_out_ok    <= n_out_ok;
        r_out_value <= n_out_value;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_whole     = r_whole;
        n_frac      = r_frac;
        n_kept      = r_kept;
        n_saw       = r_saw;
        n_fail      = r_fail;
        n_rem       = r_rem;
        n_div       = r_div;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_value = r_out_value;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && !i_end_of_text) begin
                    unique case (r_phase)
                        PH_START, PH_INT: begin
                            priority if (is_digit) begin
                                if (whole_next > 19'(WHOLE_MAX)) begin
                                    n_phase = PH_FAIL;
                                end else begin
                                    n_whole = 15'(whole_next);
                                    n_saw   = 1'b1;
                                    n_phase = PH_INT;
                                end
                            end else if (i_ch == CH_MINUS && r_phase == PH_START) begin
                                n_neg   = 1'b1;
                                n_phase = PH_INT;
                            end else if (i_ch == CH_POINT) begin
                                n_phase = PH_FRAC;
                            end else begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_FRAC: begin
                            if (is_digit) begin
                                // digits past the kept count are skipped
                                if (r_kept < KW'(MAX_FRAC_DIGITS)) begin
                                    n_frac = FRAC_W'(frac_next);
                                    n_kept = r_kept + KW'(1);
                                    n_saw  = 1'b1;
                                end
                            end else begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_FAIL: begin
                        end
                    endcase
                end else if (in_acc) begin
                    // set up (F * 2^16 + scale/2) / scale
                    n_fail  = (r_phase == PH_FAIL) || !r_saw;
                    n_rem   = DW'({r_frac, 16'b0}) + DW'(scale >> 1);
                    n_div   = DW'(scale) << FRAC_BITS;
                    n_quo   = '0;
                    n_cnt   = CW'(QUO_BITS - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (ge) begin
                    n_rem = r_rem - r_div;
                end
                n_quo = {r_quo[QUO_BITS-2:0], ge};
                n_div = r_div >> 1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_out_ok    = res_ok;
                if (!res_ok) begin
                    n_out_value = '0;
                end else if (r_neg) begin
                    n_out_value = signed'(32'(0) - raw);
                end else begin
                    n_out_value = signed'(raw);
                end
                n_phase = PH_START;
                n_neg   = 1'b0;
                n_whole = '0;
                n_frac  = '0;
                n_kept  = '0;
                n_saw   = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_ok    = r_out_ok;
    assign o_value = r_out_value;

    // no transfer while the divide runs or the result is being formed
    `DT_ASSERT_NOW(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    // a failed result carries a zero value
    `DT_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_valid && !o_ok, o_value == 32'sd0)
    // last quotient bit leads straight to the finish cycle
    `DT_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, r_state == S_DIV && r_cnt == '0,
                    r_state == S_DONE)
    // finish cycle always presents a result
    `DT_ASSERT_NEXT(a_done_out, i_clk, i_rst_n, r_state == S_DONE, o_valid)

endmodule
